// ----- src/srcomp_pkg.sv -----
// Shared types, constants and arithmetic helpers for the sensor compensation block.
// No dependencies; every other file imports this package.
package srcomp_pkg;

    localparam int Q_DEPTH      = 8;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int FRONT_STAGES = 5;
    localparam int BUSY_LEVEL   = Q_DEPTH - FRONT_STAGES;
    localparam int DIV_STEPS    = 64;
    localparam int BACK_PRE     = 12;
    localparam int POST_STAGES  = 5;

    localparam logic [63:0] PRESS_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_FULL   = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE  = 64'd3125;
    localparam logic [63:0] PRESS_BIAS47 = 64'h0000_8000_0000_0000;
    localparam logic [31:0] HUM_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_CLAMP    = 32'd419430400;
    localparam logic [31:0] HUM_BIAS     = 32'd2097152;
    localparam logic [31:0] HUM_HALF15   = 32'd16384;
    localparam logic [31:0] HUM_ONE15    = 32'd32768;
    localparam logic [31:0] HUM_HALF14   = 32'd8192;

    // register indexes on the configuration port
    localparam logic [2:0] REG_TEMP      = 3'd0;
    localparam logic [2:0] REG_PRESS_LO  = 3'd1;
    localparam logic [2:0] REG_PRESS_HI  = 3'd2;
    localparam logic [2:0] REG_PRESS_HUM = 3'd3;
    localparam logic [2:0] REG_HUM       = 3'd4;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } in_t;

    typedef struct packed {
        logic [31:0] temperature_centi;
        logic [31:0] fine_temperature;
        logic [31:0] pressure_q24_8;
        logic        pressure_invalid;
        logic [16:0] humidity_q22_10;
    } out_t;

    typedef struct packed {
        logic [47:0] temp_coeffs;
        logic [63:0] press_coeffs_low;
        logic [63:0] press_coeffs_high;
        logic [47:0] press_hum_coeffs;
        logic [39:0] hum_coeffs;
    } coef_t;

    // queue entry between front and back
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [19:0] adc_p;
        logic [15:0] adc_h;
    } q_t;

    // partial products of a 64 x 64 low-half multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] cr;
    } pp_t;

    function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
        pp_t r;
        r.ll = {32'b0, a[31:0]} * {32'b0, b[31:0]};
        r.cr = a[31:0] * b[63:32] + a[63:32] * b[31:0];
        return r;
    endfunction

    function automatic logic [63:0] pp_sum(input pp_t x);
        return x.ll + {x.cr, 32'b0};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] s);
        return 32'($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] s);
        return 64'($signed(x) >>> s);
    endfunction

    function automatic logic [63:0] sx16_64(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8_32(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

// ----- src/sensor_reading_compensation.sv -----
// Top level of the sensor compensation block: configuration registers and wiring.
// Depends on srcomp_pkg, srcomp_front, srcomp_fifo and srcomp_back.
//
// Usage:
//   Raw samples enter on the command channel: a beat is taken at a rising edge
//   with start high and busy low. Each sample gives exactly one result beat,
//   shown on result for one cycle with done high; the receiver cannot stall.
//   Latency from the accepting edge to the edge that takes the result is
//   set by the 64-step restoring divider for pressure plus the temperature
//   front stages and the multiplier stages around it. Throughput: one
//   sample per cycle while busy is low. The back never stalls, so the queue
//   between front and back stays near empty and busy stays low in practice.
//   Coefficients are written over the APB port (64-bit data, register i at
//   byte address 8*i) while no sample is in flight; pready is tied high.
//   Reset clears all coefficients (so pressure reads invalid until P1 is
//   written), empties the queue and drops every beat in flight.
module sensor_reading_compensation
    import srcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         sample,
    output logic        done,
    output out_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    coef_t       coef_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;
    logic        accept;
    logic        push, pop;
    q_t          push_data, pop_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign accept  = start && !busy;

    // coefficient bank; writes beyond the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_TEMP:      coef_reg.temp_coeffs       <= pwdata[47:0];
                REG_PRESS_LO:  coef_reg.press_coeffs_low  <= pwdata;
                REG_PRESS_HI:  coef_reg.press_coeffs_high <= pwdata;
                REG_PRESS_HUM: coef_reg.press_hum_coeffs  <= pwdata[47:0];
                REG_HUM:       coef_reg.hum_coeffs        <= pwdata[39:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TEMP:      prdata = {16'b0, coef_reg.temp_coeffs};
            REG_PRESS_LO:  prdata = coef_reg.press_coeffs_low;
            REG_PRESS_HI:  prdata = coef_reg.press_coeffs_high;
            REG_PRESS_HUM: prdata = {16'b0, coef_reg.press_hum_coeffs};
            REG_HUM:       prdata = {24'b0, coef_reg.hum_coeffs};
            default:       prdata = '0;
        endcase
    end

    // front: temperature terms
    srcomp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (sample),
        .temp_coeffs (coef_reg.temp_coeffs),
        .push        (push),
        .push_data   (push_data)
    );

    // queue; busy asserts early enough to cover beats still in the front
    srcomp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .busy      (busy)
    );

    // back: pressure, division and humidity
    srcomp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .in_data  (pop_data),
        .coef     (coef_reg),
        .done     (done),
        .result   (result)
    );

endmodule

// ----- src/srcomp_front.sv -----
// Front pipeline: takes a raw sample and works out fine and centi temperature.
// Depends on srcomp_pkg.
module srcomp_front
    import srcomp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_t         sample,
    input  logic [47:0] temp_coeffs,
    output logic        push,
    output q_t          push_data
);

    logic [31:0] t1, t2, t3;
    logic [FRONT_STAGES-1:0] vld_reg;

    logic [31:0] f1_a_reg, f1_b_reg;
    logic [31:0] f2_ma_reg, f2_mb_reg;
    logic [31:0] f3_tv1_reg, f3_mc_reg;
    logic [31:0] f4_fine_reg;
    q_t          f5_out_reg;
    logic [19:0] adc_p_reg [FRONT_STAGES-1];
    logic [15:0] adc_h_reg [FRONT_STAGES-1];

    assign t1 = {16'b0, temp_coeffs[15:0]};
    assign t2 = sx16_32(temp_coeffs[31:16]);
    assign t3 = sx16_32(temp_coeffs[47:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        f1_a_reg    <= {15'b0, sample.raw_temperature[19:3]} - {t1[30:0], 1'b0};
        f1_b_reg    <= {16'b0, sample.raw_temperature[19:4]} - t1;
        f2_ma_reg   <= f1_a_reg * t2;
        f2_mb_reg   <= f1_b_reg * f1_b_reg;
        f3_tv1_reg  <= asr32(f2_ma_reg, 6'd11);
        f3_mc_reg   <= asr32(f2_mb_reg, 6'd12) * t3;
        f4_fine_reg <= f3_tv1_reg + asr32(f3_mc_reg, 6'd14);
        // fine * 5 + 128, then arithmetic shift by 8
        f5_out_reg.temp  <= asr32({f4_fine_reg[29:0], 2'b0} + f4_fine_reg + 32'd128, 6'd8);
        f5_out_reg.fine  <= f4_fine_reg;
        f5_out_reg.adc_p <= adc_p_reg[FRONT_STAGES-2];
        f5_out_reg.adc_h <= adc_h_reg[FRONT_STAGES-2];

        adc_p_reg[0] <= sample.raw_pressure;
        adc_h_reg[0] <= sample.raw_humidity;
        for (int i = 1; i < FRONT_STAGES - 1; i++)
        begin
            adc_p_reg[i] <= adc_p_reg[i-1];
            adc_h_reg[i] <= adc_h_reg[i-1];
        end
    end

    assign push      = vld_reg[FRONT_STAGES-1];
    assign push_data = f5_out_reg;

endmodule

// ----- src/srcomp_fifo.sv -----
// Short queue between front and back; the back drains one beat per cycle.
// Depends on srcomp_pkg.
module srcomp_fifo
    import srcomp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  q_t   push_data,
    output logic pop,
    output q_t   pop_data,
    output logic busy
);

    q_t                 mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;

    assign pop      = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign busy     = (count_reg >= (Q_PTR_W+1)'(BUSY_LEVEL));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg < (Q_PTR_W+1)'(Q_DEPTH))
        else $error("push into full queue");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue not draining");
`endif

endmodule

// ----- src/srcomp_back.sv -----
// Back pipeline: pressure with pipelined 64-bit division, humidity with clamp.
// Depends on srcomp_pkg.
module srcomp_back
    import srcomp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  q_t    in_data,
    input  coef_t coef,
    output logic  done,
    output out_t  result
);

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] a;
        logic [63:0] d;
        logic        neg;
        logic        inv;
        logic [31:0] temp;
        logic [31:0] fine;
        logic [16:0] hum;
    } dv_t;

    typedef struct packed {
        logic [63:0] p;
        logic        inv;
        logic [31:0] temp;
        logic [31:0] fine;
        logic [16:0] hum;
    } pc_t;

    function automatic dv_t div_step(input dv_t s);
        dv_t         r;
        logic [64:0] r2;
        r  = s;
        r2 = {s.rem, s.a[63]};
        r.a = {s.a[62:0], 1'b0};
        if (r2 >= {1'b0, s.d})
        begin
            r.rem  = 64'(r2 - {1'b0, s.d});
            r.a[0] = 1'b1;
        end
        else
        begin
            r.rem = r2[63:0];
        end
        return r;
    endfunction

    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign p1 = {48'b0, coef.press_coeffs_low[15:0]};
    assign p2 = sx16_64(coef.press_coeffs_low[31:16]);
    assign p3 = sx16_64(coef.press_coeffs_low[47:32]);
    assign p4 = sx16_64(coef.press_coeffs_low[63:48]);
    assign p5 = sx16_64(coef.press_coeffs_high[15:0]);
    assign p6 = sx16_64(coef.press_coeffs_high[31:16]);
    assign p7 = sx16_64(coef.press_coeffs_high[47:32]);
    assign p8 = sx16_64(coef.press_coeffs_high[63:48]);
    assign p9 = sx16_64(coef.press_hum_coeffs[15:0]);
    assign h1 = {24'b0, coef.press_hum_coeffs[23:16]};
    assign h2 = sx16_32(coef.press_hum_coeffs[39:24]);
    assign h3 = {24'b0, coef.press_hum_coeffs[47:40]};
    assign h4 = sx16_32(coef.hum_coeffs[15:0]);
    assign h5 = sx16_32(coef.hum_coeffs[31:16]);
    assign h6 = sx8_32(coef.hum_coeffs[39:32]);

    logic [BACK_PRE-1:0]    b_vld_reg;
    logic [DIV_STEPS:0]     dv_vld_reg;
    logic [POST_STAGES-1:0] e_vld_reg;
    logic                   done_reg;
    q_t                     ck_reg [BACK_PRE];

    logic [63:0] b0_v1_reg;
    logic [31:0] b0_hv_reg;
    pp_t         b1_sq_reg, b1_m5_reg, b1_m2_reg;
    logic [31:0] b1_mh5_reg, b1_mh6_reg, b1_mh3_reg;
    logic [63:0] b2_sq_reg, b2_m5_reg, b2_m2_reg;
    logic [31:0] b2_x_reg, b2_ya_reg, b2_yb_reg;
    pp_t         b3_pv2_reg, b3_pa3_reg;
    logic [63:0] b3_m5_reg, b3_m2_reg;
    logic [31:0] b3_y_reg, b3_x_reg;
    logic [63:0] b4_v2a_reg, b4_a3_reg, b4_m5_reg, b4_m2_reg;
    logic [31:0] b4_y2_reg, b4_x_reg;
    logic [63:0] b5_v2_reg, b5_v1b_reg;
    logic [31:0] b5_y3_reg, b5_x_reg;
    pp_t         b6_pt_reg;
    logic [63:0] b6_nb_reg;
    logic [31:0] b6_y4_reg, b6_x_reg;
    logic [63:0] b7_t_reg;
    pp_t         b7_pn_reg;
    logic [31:0] b7_vv_reg;
    logic [63:0] b8_den_reg, b8_num_reg;
    logic [31:0] b8_w_reg, b8_vv_reg;
    logic [63:0] b9_an_reg, b9_ad_reg;
    logic        b9_neg_reg, b9_inv_reg;
    logic [31:0] b9_ww_reg, b9_vv_reg;
    logic [63:0] b10_an_reg, b10_ad_reg;
    logic        b10_neg_reg, b10_inv_reg;
    logic [31:0] b10_k_reg, b10_vv_reg;
    logic [63:0] b11_an_reg, b11_ad_reg;
    logic        b11_neg_reg, b11_inv_reg;
    logic [16:0] b11_hum_reg;
    logic [31:0] hum_v;

    dv_t         dv_reg [DIV_STEPS+1];
    pc_t         pc_reg [POST_STAGES];
    pp_t         e1_qq_reg, e1_m8_reg;
    logic [63:0] e2_qq_reg, e2_m8_reg;
    pp_t         e3_m9_reg;
    logic [63:0] e3_v2_reg, e4_v2_reg, e4_m9_reg;
    out_t        result_reg;
    logic [63:0] press;

    // humidity before clamp
    assign hum_v = b10_vv_reg - asr32(b10_k_reg, 6'd4);
    assign press = asr64(pc_reg[4].p + asr64(e4_m9_reg, 6'd25) + e4_v2_reg, 6'd8)
                   + {p7[59:0], 4'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg  <= '0;
            dv_vld_reg <= '0;
            e_vld_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            b_vld_reg  <= {b_vld_reg[BACK_PRE-2:0], in_valid};
            dv_vld_reg <= {dv_vld_reg[DIV_STEPS-1:0], b_vld_reg[BACK_PRE-1]};
            e_vld_reg  <= {e_vld_reg[POST_STAGES-2:0], dv_vld_reg[DIV_STEPS]};
            done_reg   <= e_vld_reg[POST_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        ck_reg[0] <= in_data;
        for (int i = 1; i < BACK_PRE; i++)
        begin
            ck_reg[i] <= ck_reg[i-1];
        end

        b0_v1_reg <= {{32{in_data.fine[31]}}, in_data.fine} - PRESS_OFFSET;
        b0_hv_reg <= in_data.fine - HUM_OFFSET;

        b1_sq_reg  <= mul_pp(b0_v1_reg, b0_v1_reg);
        b1_m5_reg  <= mul_pp(b0_v1_reg, p5);
        b1_m2_reg  <= mul_pp(b0_v1_reg, p2);
        b1_mh5_reg <= h5 * b0_hv_reg;
        b1_mh6_reg <= b0_hv_reg * h6;
        b1_mh3_reg <= b0_hv_reg * h3;

        b2_sq_reg <= pp_sum(b1_sq_reg);
        b2_m5_reg <= pp_sum(b1_m5_reg);
        b2_m2_reg <= pp_sum(b1_m2_reg);
        b2_x_reg  <= asr32({2'b0, ck_reg[1].adc_h, 14'b0} - {h4[11:0], 20'b0}
                           - b1_mh5_reg + HUM_HALF15, 6'd15);
        b2_ya_reg <= asr32(b1_mh6_reg, 6'd10);
        b2_yb_reg <= asr32(b1_mh3_reg, 6'd11) + HUM_ONE15;

        b3_pv2_reg <= mul_pp(b2_sq_reg, p6);
        b3_pa3_reg <= mul_pp(b2_sq_reg, p3);
        b3_m5_reg  <= b2_m5_reg;
        b3_m2_reg  <= b2_m2_reg;
        b3_y_reg   <= b2_ya_reg * b2_yb_reg;
        b3_x_reg   <= b2_x_reg;

        b4_v2a_reg <= pp_sum(b3_pv2_reg);
        b4_a3_reg  <= pp_sum(b3_pa3_reg);
        b4_m5_reg  <= b3_m5_reg;
        b4_m2_reg  <= b3_m2_reg;
        b4_y2_reg  <= asr32(b3_y_reg, 6'd10) + HUM_BIAS;
        b4_x_reg   <= b3_x_reg;

        b5_v2_reg  <= b4_v2a_reg + {b4_m5_reg[46:0], 17'b0} + {p4[28:0], 35'b0};
        b5_v1b_reg <= asr64(b4_a3_reg, 6'd8) + {b4_m2_reg[51:0], 12'b0};
        b5_y3_reg  <= b4_y2_reg * h2;
        b5_x_reg   <= b4_x_reg;

        b6_pt_reg <= mul_pp(PRESS_BIAS47 + b5_v1b_reg, p1);
        b6_nb_reg <= {(PRESS_FULL[32:0] - {13'b0, ck_reg[5].adc_p}), 31'b0} - b5_v2_reg;
        b6_y4_reg <= asr32(b5_y3_reg + HUM_HALF14, 6'd14);
        b6_x_reg  <= b5_x_reg;

        b7_t_reg  <= pp_sum(b6_pt_reg);
        b7_pn_reg <= mul_pp(b6_nb_reg, PRESS_SCALE);
        b7_vv_reg <= b6_x_reg * b6_y4_reg;

        b8_den_reg <= asr64(b7_t_reg, 6'd33);
        b8_num_reg <= pp_sum(b7_pn_reg);
        b8_w_reg   <= asr32(b7_vv_reg, 6'd15);
        b8_vv_reg  <= b7_vv_reg;

        // magnitudes for the unsigned divider; a zero divisor is parked at one
        b9_inv_reg <= (b8_den_reg == '0);
        b9_neg_reg <= b8_num_reg[63] ^ b8_den_reg[63];
        b9_an_reg  <= b8_num_reg[63] ? (64'd0 - b8_num_reg) : b8_num_reg;
        if (b8_den_reg == '0)
        begin
            b9_ad_reg <= 64'd1;
        end
        else
        begin
            b9_ad_reg <= b8_den_reg[63] ? (64'd0 - b8_den_reg) : b8_den_reg;
        end
        b9_ww_reg <= b8_w_reg * b8_w_reg;
        b9_vv_reg <= b8_vv_reg;

        b10_an_reg  <= b9_an_reg;
        b10_ad_reg  <= b9_ad_reg;
        b10_neg_reg <= b9_neg_reg;
        b10_inv_reg <= b9_inv_reg;
        b10_k_reg   <= asr32(b9_ww_reg, 6'd7) * h1;
        b10_vv_reg  <= b9_vv_reg;

        b11_an_reg  <= b10_an_reg;
        b11_ad_reg  <= b10_ad_reg;
        b11_neg_reg <= b10_neg_reg;
        b11_inv_reg <= b10_inv_reg;
        priority if (hum_v[31])
        begin
            b11_hum_reg <= '0;
        end
        else if (hum_v > HUM_CLAMP)
        begin
            b11_hum_reg <= HUM_CLAMP[28:12];
        end
        else
        begin
            b11_hum_reg <= hum_v[28:12];
        end

        dv_reg[0].rem  <= '0;
        dv_reg[0].a    <= b11_an_reg;
        dv_reg[0].d    <= b11_ad_reg;
        dv_reg[0].neg  <= b11_neg_reg;
        dv_reg[0].inv  <= b11_inv_reg;
        dv_reg[0].temp <= ck_reg[BACK_PRE-1].temp;
        dv_reg[0].fine <= ck_reg[BACK_PRE-1].fine;
        dv_reg[0].hum  <= b11_hum_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            dv_reg[i+1] <= div_step(dv_reg[i]);
        end

        pc_reg[0].p    <= dv_reg[DIV_STEPS].neg ? (64'd0 - dv_reg[DIV_STEPS].a)
                                                : dv_reg[DIV_STEPS].a;
        pc_reg[0].inv  <= dv_reg[DIV_STEPS].inv;
        pc_reg[0].temp <= dv_reg[DIV_STEPS].temp;
        pc_reg[0].fine <= dv_reg[DIV_STEPS].fine;
        pc_reg[0].hum  <= dv_reg[DIV_STEPS].hum;
        for (int i = 1; i < POST_STAGES; i++)
        begin
            pc_reg[i] <= pc_reg[i-1];
        end

        e1_qq_reg <= mul_pp(asr64(pc_reg[0].p, 6'd13), asr64(pc_reg[0].p, 6'd13));
        e1_m8_reg <= mul_pp(p8, pc_reg[0].p);
        e2_qq_reg <= pp_sum(e1_qq_reg);
        e2_m8_reg <= pp_sum(e1_m8_reg);
        e3_m9_reg <= mul_pp(p9, e2_qq_reg);
        e3_v2_reg <= asr64(e2_m8_reg, 6'd19);
        e4_m9_reg <= pp_sum(e3_m9_reg);
        e4_v2_reg <= e3_v2_reg;

        result_reg.temperature_centi <= pc_reg[4].temp;
        result_reg.fine_temperature  <= pc_reg[4].fine;
        result_reg.pressure_q24_8    <= pc_reg[4].inv ? 32'd0 : press[31:0];
        result_reg.pressure_invalid  <= pc_reg[4].inv;
        result_reg.humidity_q22_10   <= pc_reg[4].hum;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.pressure_invalid) |-> result.pressure_q24_8 == '0)
        else $error("invalid pressure not forced to zero");
    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.humidity_q22_10 <= 17'd102400)
        else $error("humidity beyond clamp");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[0] |-> dv_reg[0].d != '0)
        else $error("divider fed a zero divisor");
`endif

endmodule

// ----- verif/tb_sensor_reading_compensation.sv -----
// Testbench for sensor_reading_compensation: predicts each compensated sample and checks results.
// Depends on srcomp_pkg and the RTL of the block; self-checking, no external files.
`timescale 1ns / 100ps

module tb_sensor_reading_compensation;
    import srcomp_pkg::*;

    localparam int LATENCY   = 89;
    localparam int WDOG_MAX  = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    in_t         sample = '0;
    logic        done;
    out_t        result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // coefficient shadow used by the predictor
    coef_t       coef_shadow = '0;
    out_t        pending_results[$];
    int          mismatches = 0;
    int          beats_sent = 0;
    int          beats_seen = 0;
    int          idle_cycles = 0;
    int          send_gap_pct = 0;

    sensor_reading_compensation u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] sra32(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] sra64(logic [63:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    // truncating signed 64-bit quotient; min / -1 wraps back to min
    function automatic logic [63:0] quot64(logic [63:0] n, logic [63:0] d);
        logic [63:0] an, ad, q;
        an = n[63] ? -n : n;
        ad = d[63] ? -d : d;
        q  = an / ad;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // compensation of one raw sample under the current coefficients
    function automatic out_t compensate(in_t s, coef_t c);
        out_t        r;
        logic [31:0] t1, t2, t3, a, b, tv1, tv2, fine;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, q, press;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, w;
        logic        bad;
        t1 = {16'b0, c.temp_coeffs[15:0]};
        t2 = {{16{c.temp_coeffs[31]}}, c.temp_coeffs[31:16]};
        t3 = {{16{c.temp_coeffs[47]}}, c.temp_coeffs[47:32]};
        a = {12'b0, s.raw_temperature} >> 3;
        a = a - (t1 << 1);
        tv1 = sra32(a * t2, 11);
        b = ({12'b0, s.raw_temperature} >> 4) - t1;
        tv2 = sra32(sra32(b * b, 12) * t3, 14);
        fine = tv1 + tv2;
        r.fine_temperature  = fine;
        r.temperature_centi = sra32(fine * 32'd5 + 32'd128, 8);

        p1 = {48'b0, c.press_coeffs_low[15:0]};
        p2 = {{48{c.press_coeffs_low[31]}}, c.press_coeffs_low[31:16]};
        p3 = {{48{c.press_coeffs_low[47]}}, c.press_coeffs_low[47:32]};
        p4 = {{48{c.press_coeffs_low[63]}}, c.press_coeffs_low[63:48]};
        p5 = {{48{c.press_coeffs_high[15]}}, c.press_coeffs_high[15:0]};
        p6 = {{48{c.press_coeffs_high[31]}}, c.press_coeffs_high[31:16]};
        p7 = {{48{c.press_coeffs_high[47]}}, c.press_coeffs_high[47:32]};
        p8 = {{48{c.press_coeffs_high[63]}}, c.press_coeffs_high[63:48]};
        p9 = {{48{c.press_hum_coeffs[15]}}, c.press_hum_coeffs[15:0]};
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
        press = '0;
        bad = (v1 == 64'd0);
        if (!bad)
        begin
            p = 64'd1048576 - {44'b0, s.raw_pressure};
            p = quot64(((p << 31) - v2) * 64'd3125, v1);
            q = sra64(p, 13);
            v1 = sra64(p9 * q * q, 25);
            v2 = sra64(p8 * p, 19);
            press = sra64(p + v1 + v2, 8) + (p7 << 4);
        end
        r.pressure_q24_8   = press[31:0];
        r.pressure_invalid = bad;

        h1 = {24'b0, c.press_hum_coeffs[23:16]};
        h2 = {{16{c.press_hum_coeffs[39]}}, c.press_hum_coeffs[39:24]};
        h3 = {24'b0, c.press_hum_coeffs[47:40]};
        h4 = {{16{c.hum_coeffs[15]}}, c.hum_coeffs[15:0]};
        h5 = {{16{c.hum_coeffs[31]}}, c.hum_coeffs[31:16]};
        h6 = {{24{c.hum_coeffs[39]}}, c.hum_coeffs[39:32]};
        v = fine - 32'd76800;
        x = sra32(({16'b0, s.raw_humidity} << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
        y = sra32(v * h6, 10) * (sra32(v * h3, 11) + 32'd32768);
        y = sra32(y, 10) + 32'd2097152;
        y = sra32(y * h2 + 32'd8192, 14);
        v = x * y;
        w = sra32(v, 15);
        v = v - sra32(sra32(w * w, 7) * h1, 4);
        if (v[31])
            v = '0;
        else if (v > 32'd419430400)
            v = 32'd419430400;
        r.humidity_q22_10 = v[28:12];
        return r;
    endfunction

    // APB write: setup then access, register takes it on the access edge
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; paddr = {idx, 3'b000}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_TEMP:      coef_shadow.temp_coeffs       = val[47:0];
            REG_PRESS_LO:  coef_shadow.press_coeffs_low  = val;
            REG_PRESS_HI:  coef_shadow.press_coeffs_high = val;
            REG_PRESS_HUM: coef_shadow.press_hum_coeffs  = val[47:0];
            default:       coef_shadow.hum_coeffs        = val[39:0];
        endcase
    endtask

    task automatic load_coeffs(coef_t c);
        write_reg(REG_TEMP,      {16'b0, c.temp_coeffs});
        write_reg(REG_PRESS_LO,  c.press_coeffs_low);
        write_reg(REG_PRESS_HI,  c.press_coeffs_high);
        write_reg(REG_PRESS_HUM, {16'b0, c.press_hum_coeffs});
        write_reg(REG_HUM,       {24'b0, c.hum_coeffs});
    endtask

    // one command beat; start held across back-to-back beats
    task automatic send_sample(in_t s);
        while ($urandom_range(99) < send_gap_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start  = 1'b1;
        sample = s;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results.push_back(compensate(s, coef_shadow));
        beats_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // block is idle once nothing is pending; extra latency covers drain
    task automatic drain;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (LATENCY / 8) @(negedge clk);
    endtask

    function automatic in_t rand_sample();
        in_t s;
        s.raw_temperature = 20'($urandom);
        s.raw_pressure    = 20'($urandom);
        s.raw_humidity    = 16'($urandom);
        return s;
    endfunction

    // datasheet-like coefficients with random jitter
    function automatic coef_t plausible_coeffs();
        coef_t c;
        c.temp_coeffs       = {16'hFC18 + 16'($urandom_range(0, 99)), 16'd26435,
                               16'd27504 + 16'($urandom_range(0, 2000))};
        c.press_coeffs_low  = {16'd2855, 16'd2048 + 16'($urandom_range(0, 2000)),
                               16'hD65B, 16'd36000 + 16'($urandom_range(0, 3000))};
        c.press_coeffs_high = {16'hC6C0, 16'd15500, 16'hFFF9, 16'd140};
        c.press_hum_coeffs  = {8'd0, 16'd360 + 16'($urandom_range(0, 20)), 8'd75,
                               16'd6000};
        c.hum_coeffs        = {8'd30, 16'd50, 16'd320 + 16'($urandom_range(0, 40))};
        return c;
    endfunction

    function automatic coef_t rand_coeffs();
        coef_t c;
        c.temp_coeffs       = 48'({$urandom, $urandom});
        c.press_coeffs_low  = {$urandom, $urandom};
        c.press_coeffs_high = {$urandom, $urandom};
        c.press_hum_coeffs  = 48'({$urandom, $urandom});
        c.hum_coeffs        = 40'({$urandom, $urandom});
        return c;
    endfunction

    // result checker: every done beat against the oldest prediction
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            beats_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch beat %0d: temp %h/%h fine %h/%h",
                                  " press %h/%h inv %b/%b hum %h/%h"},
                            beats_seen, want.temperature_centi, result.temperature_centi,
                            want.fine_temperature, result.fine_temperature,
                            want.pressure_q24_8, result.pressure_q24_8,
                            want.pressure_invalid, result.pressure_invalid,
                            want.humidity_q22_10, result.humidity_q22_10);
                end
            end
        end
    end

    // watchdog: cycles with no beat in either direction and no APB access
    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("watchdog expired, %0d results outstanding", pending_results.size());
            $display("tb_sensor_reading_compensation NOT OK");
            $finish;
        end
    end

    // reset coefficients: P1 zero, so pressure must read invalid
    task automatic test_reset_defaults;
        send_sample('0);
        send_sample('1);
        send_sample(rand_sample());
        drain();
    endtask

    // field extremes under realistic coefficients
    task automatic test_extremes;
        in_t s;
        load_coeffs(plausible_coeffs());
        for (int i = 0; i < 8; i++)
        begin
            s.raw_temperature = i[0] ? 20'hFFFFF : 20'h0;
            s.raw_pressure    = i[1] ? 20'hFFFFF : 20'h0;
            s.raw_humidity    = i[2] ? 16'hFFFF : 16'h0;
            send_sample(s);
        end
        send_sample({20'h7E000, 20'h51000, 16'h6A00});
        drain();
    endtask

    // all-ones coefficients, then only P1 set
    task automatic test_coeff_extremes;
        coef_t c;
        c = '1;
        load_coeffs(c);
        for (int i = 0; i < 4; i++) send_sample(i == 0 ? in_t'('1) : rand_sample());
        drain();
        c = '0;
        c.press_coeffs_low[15:0] = 16'd1;
        load_coeffs(c);
        for (int i = 0; i < 4; i++) send_sample(i == 0 ? in_t'('0) : rand_sample());
        drain();
    endtask

    // humidity clamp: large H2 drives above the ceiling, negative below zero
    task automatic test_humidity_clamp;
        coef_t c;
        c = plausible_coeffs();
        c.press_hum_coeffs[39:24] = 16'h7FFF;
        load_coeffs(c);
        send_sample({20'h7E000, 20'h51000, 16'hFFFF});
        drain();
        c.press_hum_coeffs[39:24] = 16'h8000;
        load_coeffs(c);
        send_sample({20'h7E000, 20'h51000, 16'hFFFF});
        drain();
    endtask

    task automatic test_random(int n, int gap, bit wild);
        send_gap_pct = gap;
        for (int k = 0; k < n; k++)
        begin
            if (k % 50 == 0)
            begin
                drain();
                load_coeffs((wild && k % 100 == 0) ? rand_coeffs() : plausible_coeffs());
            end
            send_sample(rand_sample());
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_extremes();
        test_coeff_extremes();
        test_humidity_clamp();
        // sender gaps 7 %, then 68 %, then none
        test_random(150, 7, 1'b1);
        test_random(150, 68, 1'b1);
        test_random(150, 0, 1'b0);
        $display("covered %0d samples over reset, extreme, clamp and random coefficient sets",
                 beats_sent);
        $display("%0d results checked, %0d mismatches", beats_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_sensor_reading_compensation OK");
        else
            $display("tb_sensor_reading_compensation NOT OK");
        $finish;
    end

endmodule

// ----- sensor_reading_compensation.f -----
src/srcomp_pkg.sv
src/srcomp_front.sv
src/srcomp_fifo.sv
src/srcomp_back.sv
src/sensor_reading_compensation.sv
verif/tb_sensor_reading_compensation.sv
